// ===== rtl/core/tlbc_pkg.sv =====
`default_nettype none

package tlbc_pkg;

    localparam int unsigned LAYERS   = 3;
    localparam int unsigned CHANNELS = 3;
    localparam int unsigned CH_W     = 8;
    localparam int unsigned OP_W     = 9;
    localparam int unsigned BG_W     = 24;
    localparam int unsigned IDX_W    = 3;

    // Pipeline depth from input to strobe: two stages per layer plus the output register.
    localparam int unsigned LATENCY  = 2 * LAYERS + 1;

    localparam logic [OP_W-1:0] FULL_OPACITY = 9'd256;
    localparam logic [BG_W-1:0] BG_RESET     = 24'hffffff;

    typedef enum logic [2:0] {
        MODE_NORMAL     = 3'd0,
        MODE_DARKEN     = 3'd1,
        MODE_LIGHTEN    = 3'd2,
        MODE_DIFFERENCE = 3'd3,
        MODE_MULTIPLY   = 3'd4
    } mode_t;

    typedef enum logic [IDX_W-1:0] {
        REG_BACKGROUND    = 3'd0,
        REG_MODE_ONE      = 3'd1,
        REG_MODE_TWO      = 3'd2,
        REG_MODE_THREE    = 3'd3,
        REG_OPACITY_ONE   = 3'd4,
        REG_OPACITY_TWO   = 3'd5,
        REG_OPACITY_THREE = 3'd6
    } reg_index_t;

    typedef struct packed {
        mode_t            mode;
        logic [OP_W-1:0]  opacity;
    } layer_cfg_t;

    typedef struct packed {
        logic [CH_W-1:0] one_red;
        logic [CH_W-1:0] one_green;
        logic [CH_W-1:0] one_blue;
        logic [CH_W-1:0] two_red;
        logic [CH_W-1:0] two_green;
        logic [CH_W-1:0] two_blue;
        logic [CH_W-1:0] three_red;
        logic [CH_W-1:0] three_green;
        logic [CH_W-1:0] three_blue;
    } pixel_t;

    typedef struct packed {
        logic [CH_W-1:0] out_red;
        logic [CH_W-1:0] out_green;
        logic [CH_W-1:0] out_blue;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/three_layer_blend_mode_compositor.sv =====
`default_nettype none

// Three-layer blend-mode compositor. Each pixel transaction carries the
// three layer pixels; the block composites them in order over the
// background colour and returns one result per transaction. A new pixel
// may be started on every clock: busy is held low, so start alone marks a
// transaction. The result sits on result for exactly one cycle with done
// high, after passing through two stages per layer and the output register.
// The receiver cannot stall, so there is no back-pressure anywhere in the pipe.
// Configuration registers are written through wr_en/wr_index/wr_data and
// must only change while no pixel is in flight; opacities whose low nine
// bits exceed 256 are clipped to 256 on write, unused mode codes act as
// normal, and writes to index 7 are dropped.
module three_layer_blend_mode_compositor (
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    // pixel transactions
    input  wire logic                          start,
    output logic                               busy,
    input  wire tlbc_pkg::pixel_t              pixel,

    // results
    output logic                               done,
    output tlbc_pkg::result_t                  result,

    // configuration writes
    input  wire logic                          wr_en,
    input  wire logic [tlbc_pkg::IDX_W-1:0]    wr_index,
    input  wire logic [tlbc_pkg::BG_W-1:0]     wr_data
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [tlbc_pkg::BG_W-1:0]                     bg_reg;
    tlbc_pkg::layer_cfg_t [tlbc_pkg::LAYERS-1:0]   layer_reg;
    logic [tlbc_pkg::OP_W-1:0]                     opacity_sat;

    // Clip to fully opaque on the way in, so the datapath never sees > 256.
    assign opacity_sat = (wr_data[tlbc_pkg::OP_W-1:0] > tlbc_pkg::FULL_OPACITY)
                       ? tlbc_pkg::FULL_OPACITY
                       : wr_data[tlbc_pkg::OP_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bg_reg <= tlbc_pkg::BG_RESET;
            for (int l = 0; l < tlbc_pkg::LAYERS; l++)
            begin
                layer_reg[l].mode    <= tlbc_pkg::MODE_NORMAL;
                layer_reg[l].opacity <= '0;
            end
        end
        else if (wr_en)
        begin
            case (tlbc_pkg::reg_index_t'(wr_index))
                tlbc_pkg::REG_BACKGROUND:    bg_reg <= wr_data;
                tlbc_pkg::REG_MODE_ONE:
                    layer_reg[0].mode <= tlbc_pkg::mode_t'(wr_data[2:0]);
                tlbc_pkg::REG_MODE_TWO:
                    layer_reg[1].mode <= tlbc_pkg::mode_t'(wr_data[2:0]);
                tlbc_pkg::REG_MODE_THREE:
                    layer_reg[2].mode <= tlbc_pkg::mode_t'(wr_data[2:0]);
                tlbc_pkg::REG_OPACITY_ONE:   layer_reg[0].opacity <= opacity_sat;
                tlbc_pkg::REG_OPACITY_TWO:   layer_reg[1].opacity <= opacity_sat;
                tlbc_pkg::REG_OPACITY_THREE: layer_reg[2].opacity <= opacity_sat;
                default: ;   // index beyond the register list: ignored
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Lanes: one per colour channel, index 2 red .. 0 blue
    // ------------------------------------------------------------------
    logic [tlbc_pkg::CHANNELS-1:0][tlbc_pkg::LAYERS-1:0][tlbc_pkg::CH_W-1:0] lane_src;
    logic [tlbc_pkg::CHANNELS-1:0][tlbc_pkg::CH_W-1:0]                       lane_out;

    assign lane_src[2] = {pixel.three_red,   pixel.two_red,   pixel.one_red};
    assign lane_src[1] = {pixel.three_green, pixel.two_green, pixel.one_green};
    assign lane_src[0] = {pixel.three_blue,  pixel.two_blue,  pixel.one_blue};

    for (genvar c = 0; c < tlbc_pkg::CHANNELS; c++)
    begin : g_lane
        tlbc_lane u_lane (
            .clk   (clk),
            .cfg   (layer_reg),
            .bg    (bg_reg[c*tlbc_pkg::CH_W +: tlbc_pkg::CH_W]),
            .src   (lane_src[c]),
            .value (lane_out[c])
        );
    end

    // ------------------------------------------------------------------
    // Valid tracking alongside the lanes
    // ------------------------------------------------------------------
    logic [tlbc_pkg::LATENCY-2:0] valid_reg;
    logic                         done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= {valid_reg[tlbc_pkg::LATENCY-3:0], start};
            done_reg  <= valid_reg[tlbc_pkg::LATENCY-2];
        end
    end

    // ------------------------------------------------------------------
    // Merge: gather the lane results into the output register
    // ------------------------------------------------------------------
    tlbc_pkg::result_t result_reg;

    always_ff @(posedge clk)
    begin
        result_reg.out_red   <= lane_out[2];
        result_reg.out_green <= lane_out[1];
        result_reg.out_blue  <= lane_out[0];
    end

    assign busy   = 1'b0;   // fully pipelined, never refuses a pixel
    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

// ===== rtl/core/tlbc_layer.sv =====
`default_nettype none

// One layer of one channel: blend stage, then opacity mix stage.
module tlbc_layer (
    input  wire logic                          clk,
    input  wire tlbc_pkg::layer_cfg_t          cfg,
    input  wire logic [tlbc_pkg::CH_W-1:0]     base,
    input  wire logic [tlbc_pkg::CH_W-1:0]     src,
    output logic      [tlbc_pkg::CH_W-1:0]     mixed
);

    logic [2*tlbc_pkg::CH_W-1:0] prod;
    logic [tlbc_pkg::CH_W-1:0]   blend;
    logic [tlbc_pkg::CH_W-1:0]   blend_reg;
    logic [tlbc_pkg::CH_W-1:0]   base_reg;

    logic signed [tlbc_pkg::CH_W:0]      diff;
    logic signed [tlbc_pkg::OP_W:0]      alpha;
    logic signed [tlbc_pkg::CH_W+tlbc_pkg::OP_W+1:0] scaled;
    logic signed [tlbc_pkg::CH_W+tlbc_pkg::OP_W+2:0] sum;
    logic [tlbc_pkg::CH_W-1:0]   mixed_reg;

    assign prod = (2*tlbc_pkg::CH_W)'(base) * (2*tlbc_pkg::CH_W)'(src);

    always_comb
    begin
        case (cfg.mode)
            tlbc_pkg::MODE_DARKEN:     blend = (base < src) ? base : src;
            tlbc_pkg::MODE_LIGHTEN:    blend = (base > src) ? base : src;
            tlbc_pkg::MODE_DIFFERENCE: blend = (base > src) ? base - src : src - base;
            tlbc_pkg::MODE_MULTIPLY:   blend = prod[2*tlbc_pkg::CH_W-1:tlbc_pkg::CH_W];
            default:                   blend = src;   // normal and unused codes
        endcase
    end

    always_ff @(posedge clk)
    begin
        blend_reg <= blend;
        base_reg  <= base;
    end

    // a*v + (256-a)*b == 256*b + a*(v-b); a single signed multiply.
    assign diff   = $signed({1'b0, blend_reg}) - $signed({1'b0, base_reg});
    assign alpha  = $signed({1'b0, cfg.opacity});
    assign scaled = (tlbc_pkg::CH_W + tlbc_pkg::OP_W + 2)'(alpha)
                  * (tlbc_pkg::CH_W + tlbc_pkg::OP_W + 2)'(diff);
    assign sum    = $signed({4'b0000, base_reg, {tlbc_pkg::CH_W{1'b0}}})
                  + (tlbc_pkg::CH_W + tlbc_pkg::OP_W + 3)'(scaled);

    always_ff @(posedge clk)
    begin
        mixed_reg <= sum[2*tlbc_pkg::CH_W-1:tlbc_pkg::CH_W];
    end

    assign mixed = mixed_reg;

endmodule

`default_nettype wire

// ===== rtl/core/tlbc_lane.sv =====
`default_nettype none

// One colour channel through all layers, with source pixels delayed to meet
// their layer stage.
module tlbc_lane (
    input  wire logic                                            clk,
    input  wire tlbc_pkg::layer_cfg_t [tlbc_pkg::LAYERS-1:0]     cfg,
    input  wire logic [tlbc_pkg::CH_W-1:0]                       bg,
    input  wire logic [tlbc_pkg::LAYERS-1:0][tlbc_pkg::CH_W-1:0] src,
    output logic      [tlbc_pkg::CH_W-1:0]                       value
);

    logic [tlbc_pkg::LAYERS:0][tlbc_pkg::CH_W-1:0] chain;

    assign chain[0] = bg;

    for (genvar l = 0; l < tlbc_pkg::LAYERS; l++)
    begin : g_layer
        logic [tlbc_pkg::CH_W-1:0] src_at;

        if (l == 0)
        begin : g_direct
            assign src_at = src[l];
        end
        else
        begin : g_delay
            logic [2*l-1:0][tlbc_pkg::CH_W-1:0] dly_reg;

            always_ff @(posedge clk)
            begin
                dly_reg[0] <= src[l];
                for (int i = 1; i < 2*l; i++)
                begin
                    dly_reg[i] <= dly_reg[i-1];
                end
            end

            assign src_at = dly_reg[2*l-1];
        end

        tlbc_layer u_layer (
            .clk   (clk),
            .cfg   (cfg[l]),
            .base  (chain[l]),
            .src   (src_at),
            .mixed (chain[l+1])
        );
    end

    assign value = chain[tlbc_pkg::LAYERS];

endmodule

`default_nettype wire

// ===== rtl/core/tlbc_checker.sv =====
`default_nettype none

module tlbc_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic done
);

    // Pipeline never refuses work.
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

    // Every accepted transaction returns its result with done.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##7 done)
        else $error("result missing after accepted transaction");

    // No result without a transaction accepted at the matching edge.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 7))
        else $error("result without accepted transaction");

    // No result is flagged when reset is released.
    a_quiet_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !done)
        else $error("result straight out of reset");

endmodule

bind three_layer_blend_mode_compositor tlbc_checker u_tlbc_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);

`default_nettype wire
